### hdl/nnps_pkg.sv
// Shared types and constants for the nearest-neighbor preview scaler.
// No dependencies; imported by every module of the block except nnps_div.
`default_nettype none

package nnps_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAXDIM_W   = 13;

  localparam int DEF_MAX_PREVIEW_SIDE = 4096;
  localparam int DEF_MAX_SOURCE_SIDE  = 65535;

  localparam int FIFO_DEPTH = 4;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIMENSION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN_BIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THREE_CHANNEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_IS_WHITE  = 3'd5;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] RST_SRC_WIDTH  = 16'd1;
  localparam logic [CFG_DATA_W-1:0] RST_SRC_HEIGHT = 16'd1;
  localparam logic [MAXDIM_W-1:0]   RST_MAX_DIM    = 13'd1024;

  typedef struct packed {
    logic sixteen_bit;
    logic three_channel;
    logic min_is_white;
  } fmt_t;

  // one kept pixel on its way from the front to the back
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                last;
  } entry_t;

endpackage

`default_nettype wire

### hdl/nearest_neighbour_preview_scaler_top.sv
// Top level of the nearest-neighbor preview scaler.
// Depends on nnps_pkg, nnps_setup, nnps_front, nnps_fifo and nnps_back.
`default_nettype none

// Source pixels enter in raster order through a push/full queue port and the
// kept preview pixels leave through an empty/pop queue port, each with its
// preview column/row and a last_of_frame flag. After reset, and after every
// write to one of the six configuration registers, the block recomputes the
// preview size and the per-column/per-row step values with a shared
// bit-serial divider: full stays high while these are recomputed, and the
// frame restarts at the top-left pixel. From then on one source pixel is
// taken per cycle while the queue has room; the keep decision is
// incremental (quotient plus remainder per preview step), so no division
// happens per pixel. A four-entry queue sits between the position tracker
// and the color/output stage, so a stalled consumer only blocks input once
// that queue is full. cfg_ready is always high; writes to indexes beyond
// the register list are ignored and do not restart the frame. Alpha is not
// produced; treat it as 255.
module nearest_neighbour_preview_scaler_top #(
  parameter int MAX_PREVIEW_SIDE = nnps_pkg::DEF_MAX_PREVIEW_SIDE,
  parameter int MAX_SOURCE_SIDE  = nnps_pkg::DEF_MAX_SOURCE_SIDE
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // source pixel request port
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [nnps_pkg::SAMPLE_W-1:0]   in_sample_a,
  input  wire logic [nnps_pkg::SAMPLE_W-1:0]   in_sample_b,
  input  wire logic [nnps_pkg::SAMPLE_W-1:0]   in_sample_c,
  // preview pixel request port
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [nnps_pkg::PIX_W-1:0]           out_red,
  output logic [nnps_pkg::PIX_W-1:0]           out_green,
  output logic [nnps_pkg::PIX_W-1:0]           out_blue,
  output logic [nnps_pkg::COORD_W-1:0]         out_x,
  output logic [nnps_pkg::COORD_W-1:0]         out_y,
  output logic                                 out_last_of_frame,
  // configuration write port
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [nnps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nnps_pkg::CFG_DATA_W-1:0] cfg_data
);

  import nnps_pkg::*;

  localparam int SRC_W = $clog2(MAX_SOURCE_SIDE + 1);
  localparam int PW_W  = $clog2(MAX_PREVIEW_SIDE + 1);

  logic             run;
  fmt_t             fmt;
  logic [SRC_W-1:0] src_w, src_h, col_q, row_q;
  logic [PW_W-1:0]  prev_w, prev_h, col_rem, row_rem;

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wr_data, q_rd_data;

  // geometry and registers
  nnps_setup #(
    .MAX_PREVIEW_SIDE (MAX_PREVIEW_SIDE),
    .MAX_SOURCE_SIDE  (MAX_SOURCE_SIDE)
  ) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .run       (run),
    .fmt       (fmt),
    .src_w     (src_w),
    .src_h     (src_h),
    .prev_w    (prev_w),
    .prev_h    (prev_h),
    .col_q     (col_q),
    .col_rem   (col_rem),
    .row_q     (row_q),
    .row_rem   (row_rem)
  );

  // front: accept and classify
  nnps_front #(
    .MAX_PREVIEW_SIDE (MAX_PREVIEW_SIDE),
    .MAX_SOURCE_SIDE  (MAX_SOURCE_SIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .run       (run),
    .push      (push),
    .full      (full),
    .sample_a  (in_sample_a),
    .sample_b  (in_sample_b),
    .sample_c  (in_sample_c),
    .src_w     (src_w),
    .src_h     (src_h),
    .prev_w    (prev_w),
    .prev_h    (prev_h),
    .col_q     (col_q),
    .col_rem   (col_rem),
    .row_q     (row_q),
    .row_rem   (row_rem),
    .fifo_full (q_full),
    .fifo_push (q_push),
    .fifo_data (q_wr_data)
  );

  // decoupling queue
  nnps_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // back: convert and present
  nnps_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fmt           (fmt),
    .fifo_empty    (q_empty),
    .fifo_data     (q_rd_data),
    .fifo_pop      (q_pop),
    .empty         (empty),
    .pop           (pop),
    .red           (out_red),
    .green         (out_green),
    .blue          (out_blue),
    .out_x         (out_x),
    .out_y         (out_y),
    .last_of_frame (out_last_of_frame)
  );

  // a register write always restarts geometry, so input must stall
  a_cfg_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready &&
    (cfg_index == CFG_SRC_WIDTH || cfg_index == CFG_SRC_HEIGHT ||
     cfg_index == CFG_MAX_DIMENSION || cfg_index == CFG_SIXTEEN_BIT ||
     cfg_index == CFG_THREE_CHANNEL || cfg_index == CFG_MIN_IS_WHITE)
    |=> full)
    else $error("input open right after register write");

endmodule

`default_nettype wire

### hdl/nnps_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses no package items; instantiated by nnps_setup.
`default_nettype none

module nnps_div #(
  parameter int DIVIDEND_W = 30,
  parameter int DIVISOR_W  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient,
  output logic [DIVISOR_W-1:0]       remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  dvs_r;

  logic [DIVISOR_W:0] shifted;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  always_comb begin
    shifted = {rem_r, quo_r[DIVIDEND_W-1]};
    ge      = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### hdl/nnps_setup.sv
// Configuration registers and preview geometry sequencer.
// Depends on nnps_pkg and nnps_div.
`default_nettype none

module nnps_setup #(
  parameter int MAX_PREVIEW_SIDE = nnps_pkg::DEF_MAX_PREVIEW_SIDE,
  parameter int MAX_SOURCE_SIDE  = nnps_pkg::DEF_MAX_SOURCE_SIDE,
  localparam int SRC_W = $clog2(MAX_SOURCE_SIDE + 1),
  localparam int PW_W  = $clog2(MAX_PREVIEW_SIDE + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [nnps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nnps_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                    run,
  output nnps_pkg::fmt_t                          fmt,
  output logic [SRC_W-1:0]                        src_w,
  output logic [SRC_W-1:0]                        src_h,
  output logic [PW_W-1:0]                         prev_w,
  output logic [PW_W-1:0]                         prev_h,
  output logic [SRC_W-1:0]                        col_q,
  output logic [PW_W-1:0]                         col_rem,
  output logic [SRC_W-1:0]                        row_q,
  output logic [PW_W-1:0]                         row_rem
);

  import nnps_pkg::*;

  localparam int PROD_W = SRC_W + PW_W;
  localparam int DIV_W  = PROD_W + 1;

  typedef enum logic [3:0] {
    ST_SIZE, ST_MUL, ST_SHORT_GO, ST_SHORT_WAIT, ST_COL_GO, ST_COL_WAIT,
    ST_ROW_GO, ST_ROW_WAIT, ST_READY
  } state_t;

  function automatic logic [SRC_W-1:0] clamp_src(input logic [CFG_DATA_W-1:0] v);
    logic [SRC_W-1:0] r;
    r = SRC_W'(v);
    if (v == '0) r = SRC_W'(1);
    else if (32'(v) > MAX_SOURCE_SIDE) r = SRC_W'(MAX_SOURCE_SIDE);
    return r;
  endfunction

  function automatic logic [PW_W-1:0] clamp_max(input logic [MAXDIM_W-1:0] v);
    logic [PW_W-1:0] r;
    r = PW_W'(v);
    if (v == '0) r = PW_W'(1);
    else if (32'(v) > MAX_PREVIEW_SIDE) r = PW_W'(MAX_PREVIEW_SIDE);
    return r;
  endfunction

  logic [CFG_DATA_W-1:0] cfg_w_r;
  logic [CFG_DATA_W-1:0] cfg_h_r;
  logic [MAXDIM_W-1:0]   cfg_max_r;
  fmt_t                  fmt_r;
  logic                  cfg_hit;

  state_t           state_r;
  logic             wide_r;
  logic [SRC_W-1:0] w_r, h_r, long_src_r, short_src_r;
  logic [PW_W-1:0]  long_p_r, pw_r, ph_r;
  logic [DIV_W-1:0] prod_r;
  logic [SRC_W-1:0] col_q_r, row_q_r;
  logic [PW_W-1:0]  col_rem_r, row_rem_r;

  logic [SRC_W-1:0] eff_w, eff_h, eff_long;
  logic [PW_W-1:0]  eff_m, short_p;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [SRC_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [SRC_W-1:0] div_rem;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid && (cfg_index inside {[CFG_SRC_WIDTH:CFG_MIN_IS_WHITE]})) cfg_hit = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= RST_SRC_WIDTH;
      cfg_h_r   <= RST_SRC_HEIGHT;
      cfg_max_r <= RST_MAX_DIM;
      fmt_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SRC_WIDTH:     cfg_w_r             <= cfg_data;
        CFG_SRC_HEIGHT:    cfg_h_r             <= cfg_data;
        CFG_MAX_DIMENSION: cfg_max_r           <= cfg_data[MAXDIM_W-1:0];
        CFG_SIXTEEN_BIT:   fmt_r.sixteen_bit   <= cfg_data[0];
        CFG_THREE_CHANNEL: fmt_r.three_channel <= cfg_data[0];
        CFG_MIN_IS_WHITE:  fmt_r.min_is_white  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w    = clamp_src(cfg_w_r);
    eff_h    = clamp_src(cfg_h_r);
    eff_m    = clamp_max(cfg_max_r);
    eff_long = (eff_w >= eff_h) ? eff_w : eff_h;
    short_p  = (div_quo == '0) ? PW_W'(1) : PW_W'(div_quo);
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod_r;
    div_divisor  = long_src_r;
    case (state_r)
      ST_SHORT_GO: div_start = 1'b1;
      ST_COL_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(w_r);
        div_divisor  = SRC_W'(pw_r);
      end
      ST_ROW_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(h_r);
        div_divisor  = SRC_W'(ph_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SIZE;
    end else if (cfg_hit) begin
      state_r <= ST_SIZE;
    end else begin
      case (state_r)
        ST_SIZE: begin
          w_r         <= eff_w;
          h_r         <= eff_h;
          wide_r      <= eff_w >= eff_h;
          long_src_r  <= eff_long;
          short_src_r <= (eff_w >= eff_h) ? eff_h : eff_w;
          long_p_r    <= (32'(eff_long) > 32'(eff_m)) ? eff_m : PW_W'(eff_long);
          state_r     <= ST_MUL;
        end
        ST_MUL: begin
          // short * long_preview + long/2, round half up on the divide
          prod_r  <= DIV_W'(PROD_W'(short_src_r) * PROD_W'(long_p_r))
                     + DIV_W'(long_src_r >> 1);
          state_r <= ST_SHORT_GO;
        end
        ST_SHORT_GO: state_r <= ST_SHORT_WAIT;
        ST_SHORT_WAIT: begin
          if (div_done) begin
            if (wide_r) begin
              pw_r <= long_p_r;
              ph_r <= short_p;
            end else begin
              pw_r <= short_p;
              ph_r <= long_p_r;
            end
            state_r <= ST_COL_GO;
          end
        end
        ST_COL_GO: state_r <= ST_COL_WAIT;
        ST_COL_WAIT: begin
          if (div_done) begin
            col_q_r   <= SRC_W'(div_quo);
            col_rem_r <= PW_W'(div_rem);
            state_r   <= ST_ROW_GO;
          end
        end
        ST_ROW_GO: state_r <= ST_ROW_WAIT;
        ST_ROW_WAIT: begin
          if (div_done) begin
            row_q_r   <= SRC_W'(div_quo);
            row_rem_r <= PW_W'(div_rem);
            state_r   <= ST_READY;
          end
        end
        ST_READY: state_r <= ST_READY;
        default:  state_r <= ST_SIZE;
      endcase
    end
  end

  nnps_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (SRC_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign run     = (state_r == ST_READY);
  assign fmt     = fmt_r;
  assign src_w   = w_r;
  assign src_h   = h_r;
  assign prev_w  = pw_r;
  assign prev_h  = ph_r;
  assign col_q   = col_q_r;
  assign col_rem = col_rem_r;
  assign row_q   = row_q_r;
  assign row_rem = row_rem_r;

  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READY |-> (pw_r != '0) && (ph_r != '0))
    else $error("preview size zero when ready");

  a_steps_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READY |-> (col_rem_r < pw_r) && (row_rem_r < ph_r))
    else $error("step remainder not below preview size");

endmodule

`default_nettype wire

### hdl/nnps_front.sv
// Front part: source/preview position tracking and keep decision.
// Depends on nnps_pkg; pushes kept pixels into nnps_fifo.
`default_nettype none

module nnps_front #(
  parameter int MAX_PREVIEW_SIDE = nnps_pkg::DEF_MAX_PREVIEW_SIDE,
  parameter int MAX_SOURCE_SIDE  = nnps_pkg::DEF_MAX_SOURCE_SIDE,
  localparam int SRC_W = $clog2(MAX_SOURCE_SIDE + 1),
  localparam int PW_W  = $clog2(MAX_PREVIEW_SIDE + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            run,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [nnps_pkg::SAMPLE_W-1:0]   sample_a,
  input  wire logic [nnps_pkg::SAMPLE_W-1:0]   sample_b,
  input  wire logic [nnps_pkg::SAMPLE_W-1:0]   sample_c,
  input  wire logic [SRC_W-1:0]                src_w,
  input  wire logic [SRC_W-1:0]                src_h,
  input  wire logic [PW_W-1:0]                 prev_w,
  input  wire logic [PW_W-1:0]                 prev_h,
  input  wire logic [SRC_W-1:0]                col_q,
  input  wire logic [PW_W-1:0]                 col_rem,
  input  wire logic [SRC_W-1:0]                row_q,
  input  wire logic [PW_W-1:0]                 row_rem,
  input  wire logic                            fifo_full,
  output logic                                 fifo_push,
  output nnps_pkg::entry_t                     fifo_data
);

  import nnps_pkg::*;

  logic [SRC_W-1:0] scol_r, srow_r, cerr_r, rerr_r;
  logic [PW_W-1:0]  pcol_r, prow_r, crem_r, rrem_r;
  logic [SRC_W-1:0] scol_nxt, srow_nxt, cerr_nxt, rerr_nxt;
  logic [PW_W-1:0]  pcol_nxt, prow_nxt, crem_nxt, rrem_nxt;

  logic            accept, keep, col_end, row_last, src_col_end, src_row_end;
  logic [PW_W:0]   csum, rsum;
  logic            cwrap, rwrap;
  logic [PW_W-1:0] crem_step, rrem_step;
  logic [SRC_W-1:0] cerr_step, rerr_step;

  always_comb begin
    full     = !run || fifo_full;
    accept   = push && !full;
    keep     = (prow_r < prev_h) && (pcol_r < prev_w) &&
               (scol_r == cerr_r) && (srow_r == rerr_r);
    col_end  = ((PW_W+1)'(pcol_r) + 1'b1) == (PW_W+1)'(prev_w);
    row_last = ((PW_W+1)'(prow_r) + 1'b1) == (PW_W+1)'(prev_h);

    // next target = floor(k*W/pw), kept as quotient plus remainder
    csum      = (PW_W+1)'(crem_r) + (PW_W+1)'(col_rem);
    cwrap     = csum >= (PW_W+1)'(prev_w);
    crem_step = cwrap ? PW_W'(csum - (PW_W+1)'(prev_w)) : csum[PW_W-1:0];
    cerr_step = cerr_r + col_q + SRC_W'(cwrap);

    rsum      = (PW_W+1)'(rrem_r) + (PW_W+1)'(row_rem);
    rwrap     = rsum >= (PW_W+1)'(prev_h);
    rrem_step = rwrap ? PW_W'(rsum - (PW_W+1)'(prev_h)) : rsum[PW_W-1:0];
    rerr_step = rerr_r + row_q + SRC_W'(rwrap);

    src_col_end = ((SRC_W+1)'(scol_r) + 1'b1) >= (SRC_W+1)'(src_w);
    src_row_end = ((SRC_W+1)'(srow_r) + 1'b1) >= (SRC_W+1)'(src_h);

    scol_nxt = scol_r;
    srow_nxt = srow_r;
    pcol_nxt = pcol_r;
    prow_nxt = prow_r;
    cerr_nxt = cerr_r;
    rerr_nxt = rerr_r;
    crem_nxt = crem_r;
    rrem_nxt = rrem_r;

    if (accept) begin
      if (keep) begin
        if (col_end) begin
          pcol_nxt = '0;
          cerr_nxt = '0;
          crem_nxt = '0;
          prow_nxt = prow_r + 1'b1;
          rerr_nxt = rerr_step;
          rrem_nxt = rrem_step;
        end else begin
          pcol_nxt = pcol_r + 1'b1;
          cerr_nxt = cerr_step;
          crem_nxt = crem_step;
        end
      end
      scol_nxt = scol_r + 1'b1;
      if (src_col_end) begin
        scol_nxt = '0;
        srow_nxt = srow_r + 1'b1;
        if (src_row_end) begin
          // frame done, start over
          srow_nxt = '0;
          pcol_nxt = '0;
          prow_nxt = '0;
          cerr_nxt = '0;
          rerr_nxt = '0;
          crem_nxt = '0;
          rrem_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || !run) begin
      scol_r <= '0;
      srow_r <= '0;
      pcol_r <= '0;
      prow_r <= '0;
      cerr_r <= '0;
      rerr_r <= '0;
      crem_r <= '0;
      rrem_r <= '0;
    end else begin
      scol_r <= scol_nxt;
      srow_r <= srow_nxt;
      pcol_r <= pcol_nxt;
      prow_r <= prow_nxt;
      cerr_r <= cerr_nxt;
      rerr_r <= rerr_nxt;
      crem_r <= crem_nxt;
      rrem_r <= rrem_nxt;
    end
  end

  always_comb begin
    fifo_push          = accept && keep;
    fifo_data.sample_a = sample_a;
    fifo_data.sample_b = sample_b;
    fifo_data.sample_c = sample_c;
    fifo_data.x        = COORD_W'(pcol_r);
    fifo_data.y        = COORD_W'(prow_r);
    fifo_data.last     = col_end && row_last;
  end

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    run |-> (scol_r < src_w) && (srow_r < src_h))
    else $error("source position outside frame");

endmodule

`default_nettype wire

### hdl/nnps_fifo.sv
// Short queue of kept pixels between the front and the back.
// Depends on nnps_pkg (entry_t).
`default_nettype none

module nnps_fifo #(
  parameter int DEPTH = nnps_pkg::FIFO_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire nnps_pkg::entry_t  wr_data,
  output logic                   full,
  input  wire logic              pop,
  output nnps_pkg::entry_t       rd_data,
  output logic                   empty
);

  import nnps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= bump(wptr_r);
      if (pop)  rptr_r <= bump(rptr_r);
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wr_data;
  end

  assign rd_data = mem_r[rptr_r];
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

### hdl/nnps_back.sv
// Back part: 8-bit RGB conversion and the result output register.
// Depends on nnps_pkg; pops kept pixels from nnps_fifo.
`default_nettype none

module nnps_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire nnps_pkg::fmt_t               fmt,
  input  wire logic                         fifo_empty,
  input  wire nnps_pkg::entry_t             fifo_data,
  output logic                              fifo_pop,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [nnps_pkg::PIX_W-1:0]        red,
  output logic [nnps_pkg::PIX_W-1:0]        green,
  output logic [nnps_pkg::PIX_W-1:0]        blue,
  output logic [nnps_pkg::COORD_W-1:0]      out_x,
  output logic [nnps_pkg::COORD_W-1:0]      out_y,
  output logic                              last_of_frame
);

  import nnps_pkg::*;

  function automatic logic [PIX_W-1:0] to8(input logic [SAMPLE_W-1:0] s,
                                           input logic sixteen);
    return sixteen ? s[SAMPLE_W-1:SAMPLE_W-PIX_W] : s[PIX_W-1:0];
  endfunction

  logic             valid_r;
  logic             load;
  logic [PIX_W-1:0] a8, b8, c8, gray;
  logic [PIX_W-1:0] red_r, green_r, blue_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic             last_r;

  always_comb begin
    load     = !fifo_empty && (!valid_r || pop);
    fifo_pop = load;
    a8       = to8(fifo_data.sample_a, fmt.sixteen_bit);
    b8       = to8(fifo_data.sample_b, fmt.sixteen_bit);
    c8       = to8(fifo_data.sample_c, fmt.sixteen_bit);
    gray     = fmt.min_is_white ? PIX_MAX - a8 : a8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= fmt.three_channel ? a8 : gray;
      green_r <= fmt.three_channel ? b8 : gray;
      blue_r  <= fmt.three_channel ? c8 : gray;
      x_r     <= fifo_data.x;
      y_r     <= fifo_data.y;
      last_r  <= fifo_data.last;
    end
  end

  assign empty         = !valid_r;
  assign red           = red_r;
  assign green         = green_r;
  assign blue          = blue_r;
  assign out_x         = x_r;
  assign out_y         = y_r;
  assign last_of_frame = last_r;

  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !fmt.three_channel |-> (red_r == green_r) && (green_r == blue_r))
    else $error("gray result channels differ");

endmodule

`default_nettype wire

### bench/nnps_preview_checker.sv
// Scoreboard for the nearest-neighbor preview scaler: mirrors the keep decision
// and color conversion, and compares every popped preview pixel against it.
// Depends on nnps_pkg only; instantiated by nearest_neighbour_preview_scaler_top_tb.
module nnps_preview_checker #(
  parameter int MAX_PREVIEW_SIDE = nnps_pkg::DEF_MAX_PREVIEW_SIDE,
  parameter int MAX_SOURCE_SIDE  = nnps_pkg::DEF_MAX_SOURCE_SIDE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic                            full,
  input  logic [nnps_pkg::SAMPLE_W-1:0]   in_sample_a,
  input  logic [nnps_pkg::SAMPLE_W-1:0]   in_sample_b,
  input  logic [nnps_pkg::SAMPLE_W-1:0]   in_sample_c,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [nnps_pkg::PIX_W-1:0]      out_red,
  input  logic [nnps_pkg::PIX_W-1:0]      out_green,
  input  logic [nnps_pkg::PIX_W-1:0]      out_blue,
  input  logic [nnps_pkg::COORD_W-1:0]    out_x,
  input  logic [nnps_pkg::COORD_W-1:0]    out_y,
  input  logic                            out_last_of_frame,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [nnps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnps_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              n_fail,
  output int                              n_waiting,
  output int                              n_checked,
  output int                              n_frames
);
  timeunit 1ns;
  timeprecision 1ps;

  import nnps_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } preview_pix_t;

  // register copies
  int unsigned cfg_w, cfg_h, cfg_maxdim;
  fmt_t        fmt;

  // frame position and next kept source position
  int unsigned src_col, src_row;
  int unsigned pv_col, pv_row, pv_w, pv_h;
  int unsigned col_target, row_target;

  preview_pix_t expected_pix[$];
  preview_pix_t oldest;

  function automatic int unsigned clamp_side(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [PIX_W-1:0] to_byte(logic [SAMPLE_W-1:0] s);
    return fmt.sixteen_bit ? s[15:8] : s[7:0];
  endfunction

  // preview size from the registers; every call starts a fresh frame
  task automatic restart_frame();
    longint unsigned w, h, m;
    w = clamp_side(cfg_w, MAX_SOURCE_SIDE);
    h = clamp_side(cfg_h, MAX_SOURCE_SIDE);
    m = clamp_side(cfg_maxdim, MAX_PREVIEW_SIDE);
    if (w >= h) begin
      pv_w = (w > m) ? m : w;
      pv_h = (h * pv_w + w / 2) / w;
    end else begin
      pv_h = (h > m) ? m : h;
      pv_w = (w * pv_h + h / 2) / h;
    end
    if (pv_w == 0) pv_w = 1;
    if (pv_h == 0) pv_h = 1;
    src_col = 0;
    src_row = 0;
    pv_col = 0;
    pv_row = 0;
    col_target = 0;
    row_target = 0;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SRC_WIDTH:     cfg_w = data;
      CFG_SRC_HEIGHT:    cfg_h = data;
      CFG_MAX_DIMENSION: cfg_maxdim = data[MAXDIM_W-1:0];
      CFG_SIXTEEN_BIT:   fmt.sixteen_bit = data[0];
      CFG_THREE_CHANNEL: fmt.three_channel = data[0];
      CFG_MIN_IS_WHITE:  fmt.min_is_white = data[0];
      default:           return;  // unmapped index: no restart
    endcase
    restart_frame();
  endtask

  task automatic take_source(input logic [SAMPLE_W-1:0] a, b, c);
    longint unsigned w, h;
    logic [PIX_W-1:0] v;
    preview_pix_t px;
    w = clamp_side(cfg_w, MAX_SOURCE_SIDE);
    h = clamp_side(cfg_h, MAX_SOURCE_SIDE);
    if (pv_row < pv_h && pv_col < pv_w && src_row == row_target && src_col == col_target) begin
      if (fmt.three_channel) begin
        px.red   = to_byte(a);
        px.green = to_byte(b);
        px.blue  = to_byte(c);
      end else begin
        v = to_byte(a);
        if (fmt.min_is_white) v = PIX_MAX - v;
        px.red   = v;
        px.green = v;
        px.blue  = v;
      end
      px.x    = pv_col[COORD_W-1:0];
      px.y    = pv_row[COORD_W-1:0];
      px.last = (pv_col + 1 == pv_w) && (pv_row + 1 == pv_h);
      expected_pix.push_back(px);
      if (pv_col + 1 == pv_w) begin
        pv_col = 0;
        col_target = 0;
        pv_row++;
        if (pv_row < pv_h) row_target = (pv_row * h) / pv_h;
      end else begin
        pv_col++;
        col_target = (pv_col * w) / pv_w;
      end
    end
    src_col++;
    if (src_col >= w) begin
      src_col = 0;
      src_row++;
      if (src_row >= h) begin
        src_row = 0;
        pv_col = 0;
        pv_row = 0;
        col_target = 0;
        row_target = 0;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_w      = RST_SRC_WIDTH;
      cfg_h      = RST_SRC_HEIGHT;
      cfg_maxdim = RST_MAX_DIM;
      fmt        = '0;
      restart_frame();
      expected_pix.delete();
    end else begin
      // compare before predicting so a stray result can't match a fresh request
      if (pop && !empty) begin
        if (expected_pix.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected preview pixel, expected none, got x=%0d y=%0d",
                   $time, out_x, out_y);
        end else begin
          oldest = expected_pix.pop_front();
          check_field("red",   oldest.red,   out_red);
          check_field("green", oldest.green, out_green);
          check_field("blue",  oldest.blue,  out_blue);
          check_field("out_x", oldest.x,     out_x);
          check_field("out_y", oldest.y,     out_y);
          check_field("last_of_frame", oldest.last, out_last_of_frame);
          n_checked++;
          if (oldest.last) n_frames++;
        end
      end
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (push && !full) take_source(in_sample_a, in_sample_b, in_sample_c);
    end
    n_waiting <= expected_pix.size();
  end

endmodule

### bench/nearest_neighbour_preview_scaler_top_tb.sv
// Testbench top for the nearest-neighbor preview scaler: drives source pixels,
// register setups and consumer stalls; checking lives in nnps_preview_checker.
// Depends on nnps_pkg, nnps_preview_checker and the scaler RTL.
module nearest_neighbour_preview_scaler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nnps_pkg::*;

  localparam int RANDOM_ITEMS  = 1500;
  // kept pixel path: tracker, four-entry queue, color stage; generous margin
  localparam int DRAIN_CYCLES  = 24;
  localparam int FINAL_CYCLES  = 64;

  // consumer stall patterns
  typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_RARE, POP_PERIODIC} pop_mode_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  push = 1'b0;
  logic                  full;
  logic [SAMPLE_W-1:0]   in_sample_a = '0;
  logic [SAMPLE_W-1:0]   in_sample_b = '0;
  logic [SAMPLE_W-1:0]   in_sample_c = '0;

  logic                  empty;
  logic                  pop = 1'b0;
  logic [PIX_W-1:0]      out_red, out_green, out_blue;
  logic [COORD_W-1:0]    out_x, out_y;
  logic                  out_last_of_frame;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int n_fail, n_waiting, n_checked, n_frames;
  int n_sent, n_setups, burst_left;

  pop_mode_t pop_mode = POP_ALWAYS;
  int        pop_left = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  nearest_neighbour_preview_scaler_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_sample_a       (in_sample_a),
    .in_sample_b       (in_sample_b),
    .in_sample_c       (in_sample_c),
    .empty             (empty),
    .pop               (pop),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  nnps_preview_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_sample_a       (in_sample_a),
    .in_sample_b       (in_sample_b),
    .in_sample_c       (in_sample_c),
    .empty             (empty),
    .pop               (pop),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .n_fail            (n_fail),
    .n_waiting         (n_waiting),
    .n_checked         (n_checked),
    .n_frames          (n_frames)
  );

  // Consumer side: whenever the countdown runs out, pick a new stall pattern,
  // from popping every cycle to long periodic stalls that back the queue up
  // into the source port.
  always @(posedge clk) begin
    if (pop_left == 0) begin
      pop_mode <= pop_mode_t'($urandom_range(0, 3));
      pop_left <= $urandom_range(16, 200);
    end else begin
      pop_left <= pop_left - 1;
    end
    case (pop_mode)
      POP_ALWAYS: pop <= 1'b1;
      POP_HALF:   pop <= 1'($urandom_range(0, 1));
      POP_RARE:   pop <= ($urandom_range(0, 7) == 0);
      default:    pop <= ((pop_left & 31) < 4);  // on while the countdown's low five bits are below 4
    endcase
  end

  // Mostly random samples, with the all-zero/all-one/half-byte corners mixed in
  // so 8-bit and 16-bit conversion both see their extremes.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h00FF;
      3:       return 16'hFF00;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Source side: one request per call. Requests come in bursts of 1..48;
  // between bursts there is usually a gap of idle cycles, sometimes none.
  task automatic send_pixel(input logic [SAMPLE_W-1:0] a, b, c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push        <= 1'b1;
    in_sample_a <= a;
    in_sample_b <= b;
    in_sample_c <= c;
    do @(posedge clk); while (full);
    n_sent++;
  endtask

  // Hold off the source until every predicted preview pixel has been popped.
  // Always waits on a clock edge so push is not raised again in this step.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (n_waiting != 0);
  endtask

  // Idle point for register writes: drained, plus room for pixels still in
  // flight that produce no result.
  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write request. cfg_valid stays high into the next write of
  // a sequence and drops only after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  // Full register setup. With junk set, the flag writes carry random junk
  // above bit 0, which the block has to mask off.
  task automatic load_setup(input logic [CFG_DATA_W-1:0] w, h, maxdim,
                            input logic s16, rgb, miw, input bit junk);
    logic [CFG_DATA_W-2:0] pad;
    pad = junk ? (CFG_DATA_W-1)'($urandom) : '0;
    write_reg(CFG_SRC_WIDTH,     w,          1'b0);
    write_reg(CFG_SRC_HEIGHT,    h,          1'b0);
    write_reg(CFG_MAX_DIMENSION, maxdim,     1'b0);
    write_reg(CFG_SIXTEEN_BIT,   {pad, s16}, 1'b0);
    write_reg(CFG_THREE_CHANNEL, {pad, rgb}, 1'b0);
    write_reg(CFG_MIN_IS_WHITE,  {pad, miw}, 1'b1);
    n_setups++;
  endtask

  // Source side length: mostly tiny, sometimes zero, 65535 or any 16-bit value.
  function automatic logic [CFG_DATA_W-1:0] pick_side();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Preview cap: zero, exact top value, above it (upper bits of the field and
  // beyond), anything legal, or small enough to force real decimation.
  function automatic logic [CFG_DATA_W-1:0] pick_maxdim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'd4096;
      2:       return CFG_DATA_W'($urandom_range(4097, 16'hFFFF));
      3:       return CFG_DATA_W'($urandom_range(1, 4096));
      default: return CFG_DATA_W'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] w, h, md;
    int unsigned frame_px;
    int n_items, pause_at, n_random;

    // reset held from the start, released once
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // Reset setup is a 1x1 source: every pixel is a whole frame and comes back
    // with last_of_frame set. 8-bit gray, sample corners.
    send_pixel(16'h0000, pick_sample(), pick_sample());
    send_pixel(16'hFFFF, pick_sample(), pick_sample());
    send_pixel(16'h00FF, pick_sample(), pick_sample());
    send_pixel(16'hFF00, pick_sample(), pick_sample());
    settle();

    // Zero width/height fall back to 1; 16-bit gray, inverted (min-is-white).
    load_setup(16'd0, 16'd0, 16'd1024, 1'b1, 1'b0, 1'b1, 1'b0);
    send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(16'h00FF, 16'h1234, 16'h5678);
    settle();

    // Cap of zero acts as 1: a 3x2 frame shrinks to one pixel. 8-bit RGB
    // with min-is-white set, which RGB must ignore.
    load_setup(16'd3, 16'd2, 16'd0, 1'b0, 1'b1, 1'b1, 1'b0);
    repeat (6) send_pixel(pick_sample(), pick_sample(), pick_sample());
    settle();

    // Cap far above the top preview side (saturates); 5x3 is kept whole.
    // 16-bit RGB. Writes to unmapped indexes mid-frame must not restart it.
    load_setup(16'd5, 16'd3, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 16'h00FF);
    send_pixel(16'h0000, 16'hFFFF, 16'hFF00);
    send_pixel(16'hFF00, 16'h00FF, 16'hFFFF);
    send_pixel(pick_sample(), pick_sample(), pick_sample());
    settle();
    write_reg(CFG_IDX_W'(6), CFG_DATA_W'($urandom), 1'b0);
    write_reg(CFG_IDX_W'(7), CFG_DATA_W'($urandom), 1'b1);
    repeat (3) send_pixel(pick_sample(), pick_sample(), pick_sample());
    settle();

    // --- random part ---
    // Each setup runs whole frames (well-formed raster sequences), usually plus
    // a partial one, so the next register write often lands mid-frame. Huge
    // sources only get a slice of their first rows.
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      w  = pick_side();
      h  = pick_side();
      md = pick_maxdim();
      load_setup(w, h, md, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'b1);
      frame_px = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      if (frame_px <= 400) begin
        n_items = frame_px * $urandom_range(1, 3) + $urandom_range(0, frame_px);
        if (n_items > 400) n_items = 400;
      end else begin
        n_items = $urandom_range(20, 150);
      end
      // now and then the source stops mid-stream until the consumer has
      // drained every predicted pixel
      pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_items - 1) : -1;
      for (int i = 0; i < n_items; i++) begin
        if (i == pause_at) wait_drained();
        send_pixel(pick_sample(), pick_sample(), pick_sample());
      end
      n_random += n_items;
      settle();
    end

    // --- wrap-up ---
    wait_drained();
    repeat (FINAL_CYCLES) @(posedge clk);
    $display("Run covered %0d source pixels over %0d register setups (gray/RGB, 8/16-bit,",
             n_sent, n_setups);
    $display("  zero, tiny and 65535-wide sides); %0d preview pixels checked, %0d frames.",
             n_checked, n_frames);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop: far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("Timeout with %0d preview pixels still expected", n_waiting);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
